// File: src/clf_pkg.sv
// Package for the cumulative likelihood filter: widths, register codes,
// FSM state type and the elaboration-time log2 fraction function.
// No dependencies.
package clf_pkg;

  localparam int MAX_ITEMS_DEF      = 64;
  localparam int LOG_TABLE_BITS_DEF = 8;

  localparam int Q_W       = 32;   // Q1.31 word
  localparam int CNT_W_IN  = 16;   // weight_count
  localparam int SCORE_W   = 40;
  localparam int TOTAL_W   = 46;
  localparam int FRAC_W    = 16;
  localparam int NEG_W     = 21;   // Q5.16 of -log2(mix)
  localparam int IDX_OUT_W = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [Q_W-1:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIX_WEIGHT    = 1'b0,
    REG_KEEP_FRACTION = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_LOG,
    ST_TAB,
    ST_NEG,
    ST_SCR,
    ST_WR,
    ST_TGT1,
    ST_TGT2,
    ST_CRD,
    ST_CWAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_ERD,
    ST_EWAIT,
    ST_EOUT
  } state_t;

  // log2(1 + k/2^t) as 16 fraction bits, truncated repeated squaring.
  // Used only to build a constant table.
  function automatic logic [FRAC_W-1:0] log_frac(int k, int t);
    logic [63:0] x;
    logic [FRAC_W-1:0] r;
    x = 64'((64'(1) << t) + 64'(k)) << (30 - t);
    r = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      x = (x * x) >> 30;
      r = {r[FRAC_W-2:0], 1'b0};
      if (x >= (64'(1) << 31)) begin
        x = x >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [Q_W-1:0] clamp_q31(logic [Q_W-1:0] v);
    return (v > ONE_Q31) ? ONE_Q31 : v;
  endfunction

endpackage

// File: src/cumulative_likelihood_filter.sv
// Top level of the cumulative likelihood filter: score pipeline, score
// memory, threshold search and result sequencer. Depends on clf_pkg.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready   | like_one, like_two, weight_count, final_item
//  out_    | output    | out_valid/out_ready | item_index, keep, end_of_run
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// Each profile passes through ST_MUL, ST_MIX, ST_LOG, ST_TAB, ST_NEG, ST_SCR and ST_WR;
// the score is written in ST_WR, and for a non-final word in_ready returns the cycle after.
// After a final word: target in ST_TGT1 and ST_TGT2, then the search over the
// single memory read port (each candidate sweeps all N scores), skipped at fraction 1.0.
// Results then go out one at a time via ST_ERD, ST_EWAIT and ST_EOUT, held until out_ready.
// rst_n (sync) clears count, total, FSM, mix weight; keep fraction = 1.0; RAM not cleared.
module cumulative_likelihood_filter #(
  parameter int MAX_ITEMS      = clf_pkg::MAX_ITEMS_DEF,
  parameter int LOG_TABLE_BITS = clf_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [clf_pkg::Q_W-1:0]        in_like_one,
  input  logic [clf_pkg::Q_W-1:0]        in_like_two,
  input  logic [clf_pkg::CNT_W_IN-1:0]   in_weight_count,
  input  logic                           in_final_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [clf_pkg::IDX_OUT_W-1:0]  out_item_index,
  output logic                           out_keep,
  output logic                           out_end_of_run,
  input  logic                           cfg_we,
  input  logic [clf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clf_pkg::Q_W-1:0]        cfg_data
);

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int TBL = 1 << LOG_TABLE_BITS;
  localparam int T   = LOG_TABLE_BITS;

  typedef logic [clf_pkg::FRAC_W-1:0] tab_t [TBL];

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k < TBL; k++) t[k] = clf_pkg::log_frac(k, T);
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_tab();

  clf_pkg::state_t state_r, state_nxt;

  logic [clf_pkg::Q_W-1:0]     mix_weight_r, keep_fraction_r;
  logic [CW-1:0]               cnt_r;
  logic [clf_pkg::TOTAL_W-1:0] total_r;

  // payload
  logic [clf_pkg::Q_W-1:0]      l1_r, l2_r, mix_r;
  logic [clf_pkg::CNT_W_IN-1:0] n_r;
  logic                         fin_r;
  logic [63:0]                  p1_r, p2_r;
  logic [4:0]                   pos_r;
  logic [T-1:0]                 k_r;
  logic                         zero_r;
  logic [clf_pkg::FRAC_W-1:0]   frac_r;
  logic [clf_pkg::NEG_W-1:0]    neg_r;
  logic [clf_pkg::SCORE_W-1:0]  score_r, max_r, cand_r, thr_r;
  logic [clf_pkg::TOTAL_W-1:0]  hi_prod_r, target_r, sum_r;
  logic [30:0]                  lo_prod_r;
  logic                         keep_all_r, scan_vld_r;
  logic [AW-1:0]                i_r, j_r, e_r;
  logic [clf_pkg::IDX_OUT_W-1:0] out_idx_r;
  logic                         out_keep_r, out_eor_r;

  // memory
  logic [clf_pkg::SCORE_W-1:0] score_mem [MAX_ITEMS];
  logic [clf_pkg::SCORE_W-1:0] rd_data_r;
  logic [AW-1:0]               rd_addr;
  logic                        mem_we;

  logic [CW-1:0] last_idx;
  logic          store_full;
  logic [4:0]    lead_pos;
  logic [clf_pkg::Q_W+T-1:0] mix_ext;
  logic [36:0]   prod;

  assign last_idx   = cnt_r - CW'(1);
  assign store_full = (cnt_r == CW'(MAX_ITEMS));

  always_comb begin
    lead_pos = '0;
    for (int b = 0; b < clf_pkg::Q_W; b++) begin
      if (mix_r[b]) lead_pos = 5'(b);
    end
  end

  assign mix_ext = {mix_r, {T{1'b0}}} >> lead_pos;
  assign prod    = 37'(n_r) * 37'(neg_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clf_pkg::ST_IDLE:  if (in_valid) state_nxt = clf_pkg::ST_MUL;
      clf_pkg::ST_MUL:   state_nxt = clf_pkg::ST_MIX;
      clf_pkg::ST_MIX:   state_nxt = clf_pkg::ST_LOG;
      clf_pkg::ST_LOG:   state_nxt = clf_pkg::ST_TAB;
      clf_pkg::ST_TAB:   state_nxt = clf_pkg::ST_NEG;
      clf_pkg::ST_NEG:   state_nxt = clf_pkg::ST_SCR;
      clf_pkg::ST_SCR:   state_nxt = clf_pkg::ST_WR;
      clf_pkg::ST_WR: begin
        if (!fin_r) state_nxt = clf_pkg::ST_IDLE;
        else if (keep_fraction_r >= clf_pkg::ONE_Q31) state_nxt = clf_pkg::ST_ERD;
        else state_nxt = clf_pkg::ST_TGT1;
      end
      clf_pkg::ST_TGT1:  state_nxt = clf_pkg::ST_TGT2;
      clf_pkg::ST_TGT2:  state_nxt = clf_pkg::ST_CRD;
      clf_pkg::ST_CRD:   state_nxt = clf_pkg::ST_CWAIT;
      clf_pkg::ST_CWAIT: state_nxt = clf_pkg::ST_SCAN;
      clf_pkg::ST_SCAN:  if (CW'(i_r) == last_idx) state_nxt = clf_pkg::ST_DRAIN;
      clf_pkg::ST_DRAIN: state_nxt = clf_pkg::ST_EVAL;
      clf_pkg::ST_EVAL:
        state_nxt = (CW'(j_r) == last_idx) ? clf_pkg::ST_ERD : clf_pkg::ST_CRD;
      clf_pkg::ST_ERD:   state_nxt = clf_pkg::ST_EWAIT;
      clf_pkg::ST_EWAIT: state_nxt = clf_pkg::ST_EOUT;
      clf_pkg::ST_EOUT: begin
        if (out_ready)
          state_nxt = (CW'(e_r) == last_idx) ? clf_pkg::ST_IDLE : clf_pkg::ST_ERD;
      end
      default: state_nxt = clf_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = e_r;
    unique case (state_r)
      clf_pkg::ST_IDLE: in_ready  = 1'b1;
      clf_pkg::ST_WR:   mem_we    = !store_full;
      clf_pkg::ST_CRD:  rd_addr   = j_r;
      clf_pkg::ST_SCAN: rd_addr   = i_r;
      clf_pkg::ST_EOUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_item_index = out_idx_r;
  assign out_keep       = out_keep_r;
  assign out_end_of_run = out_eor_r;

  always_ff @(posedge clk) begin
    if (mem_we) score_mem[cnt_r[AW-1:0]] <= score_r;
    rd_data_r <= score_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= clf_pkg::ST_IDLE;
      mix_weight_r    <= '0;
      keep_fraction_r <= clf_pkg::ONE_Q31;
      cnt_r           <= '0;
      total_r         <= '0;
      scan_vld_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_vld_r <= (state_r == clf_pkg::ST_SCAN);
      if (cfg_we) begin
        case (clf_pkg::cfg_reg_t'(cfg_index))
          clf_pkg::REG_MIX_WEIGHT:    mix_weight_r    <= cfg_data;
          clf_pkg::REG_KEEP_FRACTION: keep_fraction_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == clf_pkg::ST_WR && !store_full) begin
        cnt_r   <= cnt_r + CW'(1);
        total_r <= total_r + clf_pkg::TOTAL_W'(score_r);
      end
      if (state_r == clf_pkg::ST_EOUT && out_ready && CW'(e_r) == last_idx) begin
        cnt_r   <= '0;
        total_r <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      clf_pkg::ST_IDLE: begin
        l1_r  <= clf_pkg::clamp_q31(in_like_one);
        l2_r  <= clf_pkg::clamp_q31(in_like_two);
        n_r   <= in_weight_count;
        fin_r <= in_final_item;
      end
      clf_pkg::ST_MUL: begin
        p1_r <= 64'(l1_r) * 64'(clf_pkg::ONE_Q31 - clf_pkg::clamp_q31(mix_weight_r));
        p2_r <= 64'(l2_r) * 64'(clf_pkg::clamp_q31(mix_weight_r));
      end
      clf_pkg::ST_MIX: mix_r <= 32'((p1_r + p2_r) >> 31);
      clf_pkg::ST_LOG: begin
        pos_r  <= lead_pos;
        k_r    <= mix_ext[T-1:0];
        zero_r <= (mix_r == '0);
      end
      clf_pkg::ST_TAB: frac_r <= LOG_TAB[k_r];
      clf_pkg::ST_NEG:
        neg_r <= {5'd31 - pos_r, 16'h0000} - clf_pkg::NEG_W'(frac_r);
      clf_pkg::ST_SCR: begin
        // n * neg stays below 2^37, so only the zero mix case saturates
        if (zero_r) score_r <= (n_r != '0) ? clf_pkg::SCORE_MAX : '0;
        else        score_r <= clf_pkg::SCORE_W'(prod);
      end
      clf_pkg::ST_WR: begin
        if (!store_full && (cnt_r == '0 || score_r > max_r)) max_r <= score_r;
        keep_all_r <= (keep_fraction_r >= clf_pkg::ONE_Q31);
        e_r <= '0;
        j_r <= '0;
      end
      clf_pkg::ST_TGT1: begin
        hi_prod_r <= clf_pkg::TOTAL_W'(total_r[45:31] * keep_fraction_r[30:0]);
        lo_prod_r <= 31'((62'(total_r[30:0]) * 62'(keep_fraction_r[30:0])) >> 31);
      end
      clf_pkg::ST_TGT2: begin
        target_r <= hi_prod_r + clf_pkg::TOTAL_W'(lo_prod_r);
        thr_r    <= max_r;
      end
      clf_pkg::ST_CWAIT: begin
        cand_r <= rd_data_r;
        sum_r  <= '0;
        i_r    <= '0;
      end
      clf_pkg::ST_SCAN: i_r <= i_r + AW'(1);
      // threshold = smallest score whose strictly-larger mass is below target
      clf_pkg::ST_EVAL: begin
        if (sum_r < target_r && cand_r < thr_r) thr_r <= cand_r;
        j_r <= j_r + AW'(1);
      end
      clf_pkg::ST_EWAIT: begin
        out_idx_r  <= clf_pkg::IDX_OUT_W'(e_r);
        out_keep_r <= keep_all_r || (rd_data_r >= thr_r);
        out_eor_r  <= (CW'(e_r) == last_idx);
      end
      clf_pkg::ST_EOUT: if (out_ready) e_r <= e_r + AW'(1);
      default: ;
    endcase
    if (scan_vld_r && rd_data_r > cand_r)
      sum_r <= sum_r + clf_pkg::TOTAL_W'(rd_data_r);
  end

endmodule

// File: sim/tb_cumulative_likelihood_filter.sv
// Self-checking testbench for cumulative_likelihood_filter: profile sets with directed and
// random content, checked word by word against a built-in score/threshold predictor.
// Depends on clf_pkg and the cumulative_likelihood_filter RTL.
module tb_cumulative_likelihood_filter;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [5:0] idx;
    bit       keep;
    bit       last;
  } keep_flag_t;

  class scoreboard;
    bit [63:0]  mix_w, keep_frac;
    bit [63:0]  scores[64];
    int         loaded;
    bit [45:0]  total;
    keep_flag_t pending_flags[$];
    int         errors, words_in, words_out, sets_done;

    function new();
      mix_w = 0;
      keep_frac = 64'h8000_0000;
      loaded = 0;
      total = 0;
    endfunction

    function void set_reg(clf_pkg::cfg_reg_t r, bit [31:0] v);
      if (r == clf_pkg::REG_MIX_WEIGHT) mix_w = v;
      else keep_frac = v;
    endfunction

    function bit [63:0] sat_q31(bit [31:0] v);
      return (v > 32'h8000_0000) ? 64'h8000_0000 : {32'd0, v};
    endfunction

    // log2(1 + k/256) in 16 fraction bits by repeated squaring
    function bit [15:0] log_fraction(bit [7:0] k);
      bit [63:0] x;
      bit [15:0] r;
      x = (64'd256 + k) << 22;
      r = 0;
      for (int i = 0; i < 16; i++) begin
        x = (x * x) >> 30;
        r = r << 1;
        if (x >= 64'h8000_0000) begin
          x = x >> 1;
          r[0] = 1'b1;
        end
      end
      return r;
    endfunction

    function bit [63:0] profile_score(bit [31:0] l1, bit [31:0] l2, bit [15:0] n);
      bit [63:0] w, mix, neg, s;
      int p;
      bit [7:0] k;
      w = sat_q31(mix_w[31:0]);
      mix = (sat_q31(l1) * (64'h8000_0000 - w) + sat_q31(l2) * w) >> 31;
      if (mix == 0) return (n != 0) ? 64'hFF_FFFF_FFFF : 0;
      p = 0;
      while (p < 31 && (mix >> (p + 1)) != 0) p++;
      if (p >= 8) k = 8'(mix >> (p - 8));
      else k = 8'(mix << (8 - p));
      neg = (64'(31 - p) << 16) - log_fraction(k);
      s = n * neg;
      return (s > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : s;
    endfunction

    function void note_word(bit [31:0] l1, bit [31:0] l2, bit [15:0] n, bit fin);
      bit [63:0] ranked[];
      bit [79:0] prod;
      bit [63:0] target, sum, thr;
      bit all_kept;
      keep_flag_t f;
      words_in++;
      if (loaded < 64) begin
        scores[loaded] = profile_score(l1, l2, n);
        total = total + scores[loaded][45:0];
        loaded++;
      end
      if (!fin) return;
      all_kept = keep_frac[31:0] >= 32'h8000_0000;
      thr = 0;
      if (!all_kept && loaded > 0) begin
        ranked = new[loaded];
        for (int i = 0; i < loaded; i++) ranked[i] = scores[i];
        ranked.rsort();
        prod = total * keep_frac[31:0];
        target = 64'(prod >> 31);
        sum = ranked[0];
        thr = ranked[0];
        for (int i = 1; i < loaded && sum < target; i++) begin
          sum += ranked[i];
          thr = ranked[i];
        end
      end
      for (int i = 0; i < loaded; i++) begin
        f.idx = 6'(i);
        f.keep = all_kept || scores[i] >= thr;
        f.last = (i + 1 == loaded);
        pending_flags.push_back(f);
      end
      loaded = 0;
      total = 0;
      sets_done++;
    endfunction

    task report(string what, int got, int want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(bit [5:0] idx, bit keep, bit last);
      keep_flag_t f;
      words_out++;
      if (pending_flags.size() == 0) begin
        report("unexpected result word, index", idx, -1);
        return;
      end
      f = pending_flags.pop_front();
      if (idx != f.idx) report("item_index", idx, f.idx);
      if (keep != f.keep) report("keep", keep, f.keep);
      if (last != f.last) report("end_of_run", last, f.last);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [clf_pkg::Q_W-1:0] in_like_one = '0, in_like_two = '0;
  logic [clf_pkg::CNT_W_IN-1:0] in_weight_count = '0;
  logic in_final_item = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [clf_pkg::IDX_OUT_W-1:0] out_item_index;
  logic out_keep, out_end_of_run;
  logic cfg_we = 1'b0;
  logic [clf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [clf_pkg::Q_W-1:0] cfg_data = '0;

  scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  cumulative_likelihood_filter uut (.*);

  always #6 clk = ~clk;

  initial begin
    #(12ns * 2_000_000);
    $display("cumulative_likelihood_filter: mismatch");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_word(in_like_one, in_like_two, in_weight_count, in_final_item);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_item_index, out_keep, out_end_of_run);
  end

  task send_word(bit [31:0] l1, bit [31:0] l2, bit [15:0] n, bit fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_like_one = l1;
    in_like_two = l2;
    in_weight_count = n;
    in_final_item = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task wait_idle();
    while (sb.pending_flags.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task write_reg(clf_pkg::cfg_reg_t r, bit [31:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = r;
    cfg_data = v;
    sb.set_reg(r, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function bit [31:0] rand_like();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return $urandom();
      2: return $urandom_range(255);
      3: return 32'h8000_0000;
      default: return $urandom_range(32'h8000_0000);
    endcase
  endfunction

  function bit [15:0] rand_count();
    return ($urandom_range(2) == 0) ? 16'($urandom()) : 16'($urandom_range(20));
  endfunction

  function bit [31:0] rand_q31();
    case ($urandom_range(4))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return $urandom_range(32'h7FFF_FFFF);
    endcase
  endfunction

  task send_set(int n);
    bit [31:0] l1, l2;
    bit [15:0] c;
    for (int i = 0; i < n; i++) begin
      // repeat the previous profile now and then to make ties
      if (i == 0 || $urandom_range(3) != 0) begin
        l1 = rand_like();
        l2 = rand_like();
        c = rand_count();
      end
      send_word(l1, l2, c, i == n - 1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: w = 0, keep everything; zero mix, clamping, extreme counts
    send_word(32'h0, 32'hFFFF_FFFF, 16'd5, 1'b0);
    send_word(32'h0, 32'h0, 16'd0, 1'b0);
    send_word(32'h8000_0000, 32'h0, 16'hFFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 32'h1, 16'd1, 1'b0);
    send_word(32'h1, 32'h8000_0000, 16'hFFFF, 1'b1);
    wait_idle();
    // full weight on like_two, zero fraction, ties below the top score
    write_reg(clf_pkg::REG_MIX_WEIGHT, 32'h8000_0000);
    write_reg(clf_pkg::REG_KEEP_FRACTION, 32'h0);
    send_word(32'h5555_5555, 32'h0100_0000, 16'd7, 1'b0);
    send_word(32'h1234_5678, 32'h0100_0000, 16'd7, 1'b0);
    send_word(32'h0, 32'h4000_0000, 16'd7, 1'b0);
    send_word(32'h0, 32'h0000_0003, 16'd2, 1'b1);
    wait_idle();
    write_reg(clf_pkg::REG_MIX_WEIGHT, 32'hFFFF_FFFF);
    write_reg(clf_pkg::REG_KEEP_FRACTION, 32'h4000_0000);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd100, 1'b0);
    send_word(32'h0, 32'h0000_FFFF, 16'd3, 1'b0);
    send_word(32'hAAAA_AAAA, 32'h2000_0000, 16'd100, 1'b0);
    send_word(32'h0, 32'h0000_0100, 16'd1, 1'b1);
    wait_idle();
    write_reg(clf_pkg::REG_MIX_WEIGHT, 32'h4000_0000);
    write_reg(clf_pkg::REG_KEEP_FRACTION, 32'hFFFF_FFFF);
    send_word(32'h1000_0000, 32'h0000_0010, 16'd9, 1'b0);
    send_word(32'h0, 32'h0, 16'd4, 1'b0);
    send_word(32'h0F0F_0F0F, 32'hF0F0_F0F0, 16'd9, 1'b1);
    wait_idle();
    write_reg(clf_pkg::REG_KEEP_FRACTION, 32'h7FFF_FFFF);
    send_word(32'h0000_0001, 32'h0000_0002, 16'd1, 1'b1);
    wait_idle();

    // one set past the store size; the extra words are dropped but the final ends it
    write_reg(clf_pkg::REG_KEEP_FRACTION, 32'h6000_0000);
    send_set(66);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 30 : 0;
      for (int s = 0; s < 8; s++) begin
        if ($urandom_range(2) == 0) begin
          wait_idle();
          write_reg(clf_pkg::REG_MIX_WEIGHT, rand_q31());
          write_reg(clf_pkg::REG_KEEP_FRACTION, rand_q31());
        end
        // long receiver stall while the next set keeps coming
        if (phase == 2 && s == 3) hold_left = 400;
        send_set($urandom_range(1, 3));
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Covered %0d profile words in %0d sets, %0d result words checked,",
             sb.words_in, sb.sets_done, sb.words_out);
    $display("including a set past the store size and several weight/fraction settings.");
    if (sb.errors == 0 && sb.pending_flags.size() == 0) begin
      $display("cumulative_likelihood_filter: match");
    end else begin
      $display("cumulative_likelihood_filter: mismatch");
    end
    $finish;
  end
endmodule
